// ===== rtl/mpm_pkg.sv =====
// Shared types and constants for the magnitude pruning mask block.
// Used by every module in rtl; depends on nothing.
`default_nettype none
package mpm_pkg;
  localparam int WEIGHT_BITS = 16;
  localparam int INDEX_BITS = 10;
  localparam int PCOUNT_BITS = 11;
  localparam int FRAC_BITS = 17;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'h10000;
  localparam logic [FRAC_BITS-1:0] FRAC_RESET = 17'h08000;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [1:0] {OP_LOAD, OP_LOAD_LAST, OP_READ} op_code_t;

  typedef struct packed {
    logic                         cmd;
    logic signed [WEIGHT_BITS-1:0] weight_in;
    logic                         last_weight;
    logic [INDEX_BITS-1:0]        entry_index;
  } in_item_t;

  typedef struct packed {
    logic                         result_kind;
    logic [WEIGHT_BITS-1:0]       threshold;
    logic [PCOUNT_BITS-1:0]       prune_count;
    logic                         keep_bit;
    logic signed [WEIGHT_BITS-1:0] masked_weight;
    logic [1:0]                   status;
  } out_item_t;

  typedef struct packed {
    op_code_t                     op;
    logic [WEIGHT_BITS-1:0]       weight;
    logic [INDEX_BITS-1:0]        index;
  } op_item_t;

  function automatic logic [WEIGHT_BITS-1:0] mag_of(input logic [WEIGHT_BITS-1:0] w);
    mag_of = w[WEIGHT_BITS-1] ? (~w + 1'b1) : w;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/mpm_front.sv =====
// Front end: accepts items, classifies them into operations, two-entry queue.
// Depends on mpm_pkg.
`default_nettype none
module mpm_front import mpm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  output logic          q_valid,
  input  wire logic     q_pop,
  output op_item_t      q_item
);
  op_item_t slot_r [2];
  logic     rd_ptr_r, wr_ptr_r;
  logic [1:0] fill_r;
  op_item_t op_c;
  logic     push;

  always_comb begin
    op_c.weight = in_item.weight_in;
    op_c.index  = in_item.entry_index;
    if (in_item.cmd) begin
      op_c.op = OP_READ;
    end else if (in_item.last_weight) begin
      op_c.op = OP_LOAD_LAST;
    end else begin
      op_c.op = OP_LOAD;
    end
  end

  assign in_ready = (fill_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill_r != 2'd0);
  assign q_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= op_c;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mpm_back.sv =====
// Back end: weight store, k and threshold selection by bitwise search, readback.
// Depends on mpm_pkg.
`default_nettype none
module mpm_back import mpm_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [FRAC_BITS-1:0] cfg_wr_data,
  input  wire logic                 q_valid,
  output logic                      q_pop,
  input  wire op_item_t             q_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item
);
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int BW = $clog2(WEIGHT_BITS);

  typedef enum logic [2:0] {S_IDLE, S_READ, S_K, S_SCAN, S_DRAIN, S_DECIDE} state_t;

  logic [WEIGHT_BITS-1:0] mem [STORE_DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_r;
  logic                   scan_vld_r;

  state_t                 state_r;
  logic [FRAC_BITS-1:0]   frac_r;
  logic [CW-1:0]          count_r, k_r, scan_idx_r, lt_cnt_r;
  logic [WEIGHT_BITS-1:0] thr_r, prefix_r;
  logic [BW-1:0]          bit_r;
  logic                   load_open_r;
  logic [1:0]             sel_status_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic                   out_free, is_load, full, we, out_set;
  logic [CW-1:0]          c_eff;
  logic [AW-1:0]          rd_addr;
  logic [FRAC_BITS-1:0]   frac_sat;
  logic [CW+FRAC_BITS-1:0] prod;
  logic [CW-1:0]          k_c;
  logic [WEIGHT_BITS-1:0] trial, rmag;
  logic                   in_range;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop = (state_r == S_IDLE) && q_valid && out_free;
  assign is_load = (q_item.op != OP_READ);
  assign c_eff = load_open_r ? count_r : '0;
  assign full = (c_eff >= CW'(STORE_DEPTH));
  assign we = q_pop && is_load && !full;
  assign in_range = (32'(q_item.index) < 32'(count_r));
  assign frac_sat = (frac_r > FRAC_ONE) ? FRAC_ONE : frac_r;
  assign prod = (CW+FRAC_BITS)'(count_r) * (CW+FRAC_BITS)'(frac_sat);
  assign k_c = CW'(prod >> 16);
  assign trial = prefix_r | (WEIGHT_BITS'(1) << bit_r);
  assign rmag = mag_of(rdata_r);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // a new result is loaded this cycle
  assign out_set = ((state_r == S_IDLE) && q_pop &&
                    (is_load ? ((q_item.op != OP_LOAD_LAST) && full) : !in_range)) ||
                   (state_r == S_READ) || ((state_r == S_K) && (k_c == '0)) ||
                   ((state_r == S_DECIDE) && (bit_r == '0));

  always_comb begin
    if (state_r == S_SCAN) begin
      rd_addr = AW'(scan_idx_r);
    end else begin
      rd_addr = AW'(32'(q_item.index));
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(c_eff)] <= q_item.weight;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      frac_r <= FRAC_RESET;
      count_r <= '0;
      k_r <= '0;
      thr_r <= '0;
      load_open_r <= 1'b1;
      out_valid_r <= 1'b0;
      scan_vld_r <= 1'b0;
      scan_idx_r <= '0;
      lt_cnt_r <= '0;
      prefix_r <= '0;
      bit_r <= '0;
      sel_status_r <= ST_OK;
    end else begin
      if (cfg_wr_en) frac_r <= cfg_wr_data;
      if (out_valid_r && out_ready && !out_set) out_valid_r <= 1'b0;
      scan_vld_r <= (state_r == S_SCAN);
      if (scan_vld_r && (rmag < trial)) lt_cnt_r <= lt_cnt_r + 1'b1;
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (is_load) begin
              count_r <= full ? c_eff : c_eff + 1'b1;
              if (q_item.op == OP_LOAD_LAST) begin
                load_open_r <= 1'b0;
                sel_status_r <= full ? ST_FULL : ST_OK;
                state_r <= S_K;
              end else begin
                load_open_r <= 1'b1;
                if (full) begin
                  out_valid_r <= 1'b1;
                  out_r <= '{KIND_REPORT, thr_r, PCOUNT_BITS'(k_r), 1'b0, '0, ST_FULL};
                end
              end
            end else if (in_range) begin
              state_r <= S_READ;
            end else begin
              out_valid_r <= 1'b1;
              out_r <= '{KIND_READ, thr_r, PCOUNT_BITS'(k_r), 1'b0, '0, ST_RANGE};
            end
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_r <= '{KIND_READ, thr_r, PCOUNT_BITS'(k_r), (rmag > thr_r),
                     (rmag > thr_r) ? rdata_r : '0, ST_OK};
          state_r <= S_IDLE;
        end
        S_K: begin
          k_r <= k_c;
          if (k_c == '0) begin
            thr_r <= '0;
            out_valid_r <= 1'b1;
            out_r <= '{KIND_REPORT, '0, '0, 1'b0, '0, sel_status_r};
            state_r <= S_IDLE;
          end else begin
            prefix_r <= '0;
            bit_r <= BW'(WEIGHT_BITS - 1);
            scan_idx_r <= '0;
            lt_cnt_r <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // walk every stored entry, one read a cycle
          if (scan_idx_r == count_r - 1'b1) begin
            state_r <= S_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
        end
        S_DRAIN: begin
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          // keep the trial bit while fewer than k magnitudes lie below it
          if (bit_r == '0) begin
            thr_r <= (lt_cnt_r < k_r) ? trial : prefix_r;
            out_valid_r <= 1'b1;
            out_r <= '{KIND_REPORT, (lt_cnt_r < k_r) ? trial : prefix_r,
                       PCOUNT_BITS'(k_r), 1'b0, '0, sel_status_r};
            state_r <= S_IDLE;
          end else begin
            if (lt_cnt_r < k_r) prefix_r <= trial;
            bit_r <= bit_r - 1'b1;
            scan_idx_r <= '0;
            lt_cnt_r <= '0;
            state_r <= S_SCAN;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/magnitude_prune_mask.sv =====
// Top level: front queue feeding the store and selection back end.
// Loads: one item a cycle while the output is not stalled; a readback's result is
// registered before the next item is taken. Last load: threshold report set by one
// search pass over the store's single read port per bit; the search is skipped when k is 0.
// Synchronous active-low reset: empty store, threshold 0, sparsity one half.
`default_nettype none
module magnitude_prune_mask import mpm_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [FRAC_BITS-1:0] cfg_wr_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item
);
  logic     q_valid, q_pop;
  op_item_t q_item;

  mpm_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  mpm_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );
endmodule
`default_nettype wire

// ===== tb/mpm_checker.sv =====
// Scoreboard for magnitude_prune_mask: watches both channels and the config port,
// predicts every result from its own copy of the store and compares. Needs mpm_pkg.
`timescale 1ns / 1ps
module mpm_checker import mpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [FRAC_BITS-1:0] cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_item,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_item,
  output int                   fail_count,
  output int                   pending,
  output int                   checked
);
  localparam logic CMD_READ = 1'b1;

  logic [WEIGHT_BITS-1:0] weights [STORE_DEPTH_DEF];
  int unsigned            stored;
  logic                   tensor_open;
  logic [WEIGHT_BITS:0]   cut_mag;
  int unsigned            cut_k;
  logic [FRAC_BITS-1:0]   frac;
  out_item_t              expected_q [$];

  assign pending = expected_q.size();

  // one bit wider than a weight so the most negative value keeps its magnitude
  function automatic logic [WEIGHT_BITS:0] abs_wide(input logic [WEIGHT_BITS-1:0] w);
    abs_wide = w[WEIGHT_BITS-1] ? (17'h10000 - {1'b0, w}) : {1'b0, w};
  endfunction

  task automatic pick_threshold();
    int unsigned   f;
    int unsigned   mags [$];
    f = (frac > FRAC_ONE) ? FRAC_ONE : frac;
    cut_k = (longint'(stored) * f) >> 16;
    cut_mag = '0;
    if (cut_k != 0) begin
      for (int i = 0; i < stored; i++) mags.push_back(abs_wide(weights[i]));
      mags.sort();
      cut_mag = mags[cut_k-1];
    end
  endtask

  task automatic predict(input in_item_t it);
    out_item_t r;
    logic [1:0] st;
    logic       emit;
    r = '0;
    emit = 1'b0;
    if (it.cmd == CMD_READ) begin
      r.result_kind = KIND_READ;
      emit = 1'b1;
      if (it.entry_index >= stored) begin
        r.status = ST_RANGE;
      end else begin
        r.status = ST_OK;
        r.keep_bit = abs_wide(weights[it.entry_index]) > cut_mag;
        r.masked_weight = r.keep_bit ? weights[it.entry_index] : '0;
      end
    end else begin
      st = ST_OK;
      if (!tensor_open) begin
        stored = 0;
        tensor_open = 1'b1;
      end
      if (stored >= STORE_DEPTH_DEF) st = ST_FULL;
      else begin
        weights[stored] = it.weight_in;
        stored++;
      end
      if (it.last_weight) begin
        pick_threshold();
        tensor_open = 1'b0;
      end
      emit = it.last_weight || (st != ST_OK);
      r.result_kind = KIND_REPORT;
      r.status = st;
    end
    r.threshold = cut_mag[WEIGHT_BITS-1:0];
    r.prune_count = cut_k[PCOUNT_BITS-1:0];
    if (emit) expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored = 0;
      tensor_open = 1'b1;
      cut_mag = '0;
      cut_k = 0;
      frac = FRAC_RESET;
      expected_q.delete();
    end else begin
      if (cfg_wr_en) frac = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_item);
        end else begin
          out_item_t e;
          e = expected_q.pop_front();
          checked++;
          if (out_item.result_kind !== e.result_kind || out_item.threshold !== e.threshold ||
              out_item.prune_count !== e.prune_count || out_item.keep_bit !== e.keep_bit ||
              out_item.masked_weight !== e.masked_weight || out_item.status !== e.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %p, got %p", e, out_item);
          end
        end
      end
      if (in_valid && in_ready) predict(in_item);
    end
  end

  initial begin
    fail_count = 0;
    checked = 0;
  end
endmodule

// ===== tb/tb_magnitude_prune_mask.sv =====
// Top of the magnitude_prune_mask testbench: clock, reset, stimulus and verdict.
// Depends on mpm_pkg, the block and tb/mpm_checker.sv.
`timescale 1ns / 1ps
module tb_magnitude_prune_mask;
  import mpm_pkg::*;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [FRAC_BITS-1:0] cfg_wr_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;

  int fail_count, pending, checked;
  int tx_idle, rx_idle;
  int n_sent, n_tensors, n_cfg;
  int unsigned shadow_count;
  bit shadow_open;

  magnitude_prune_mask dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  mpm_checker scoreboard (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

  task automatic send(input logic cmd, input logic [WEIGHT_BITS-1:0] w,
                      input logic last, input logic [INDEX_BITS-1:0] idx);
    in_item_t it;
    it.cmd = cmd;
    it.weight_in = w;
    it.last_weight = last;
    it.entry_index = idx;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    if (cmd == CMD_LOAD) begin
      if (!shadow_open) begin
        shadow_count = 0;
        shadow_open = 1'b1;
      end
      if (shadow_count < STORE_DEPTH_DEF) shadow_count++;
      if (last) begin
        shadow_open = 1'b0;
        n_tensors++;
      end
    end
  endtask

  // hold off until every expected result is in, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_frac(input logic [FRAC_BITS-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    n_cfg++;
  endtask

  function automatic logic [WEIGHT_BITS-1:0] pick_weight();
    case ($urandom_range(7))
      0: pick_weight = 16'h8000;
      1: pick_weight = 16'h7fff;
      2: pick_weight = '0;
      3: pick_weight = WEIGHT_BITS'($urandom_range(1) ? -$urandom_range(4) : $urandom_range(4));
      default: pick_weight = WEIGHT_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] pick_frac();
    case ($urandom_range(6))
      0: pick_frac = '0;
      1: pick_frac = FRAC_ONE;
      2: pick_frac = 17'h1ffff;
      3: pick_frac = 17'd1;
      4: pick_frac = FRAC_BITS'($urandom_range(131071));
      default: pick_frac = FRAC_BITS'($urandom_range(65536));
    endcase
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index();
    if ($urandom_range(99) < 85 && shadow_count != 0)
      pick_index = INDEX_BITS'($urandom_range(shadow_count - 1));
    else if (shadow_count < STORE_DEPTH_DEF)
      pick_index = INDEX_BITS'($urandom_range(1023, shadow_count));
    else
      pick_index = INDEX_BITS'($urandom);
  endfunction

  task automatic random_read();
    send(CMD_READ, WEIGHT_BITS'($urandom), 1'($urandom_range(1)), pick_index());
  endtask

  // one tensor: loads with the odd stray read, the last load, then readbacks
  task automatic random_tensor();
    int size;
    size = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(24, 1);
    for (int i = 0; i < size; i++) begin
      if ($urandom_range(7) == 0) random_read();
      send(CMD_LOAD, pick_weight(), i == size - 1, INDEX_BITS'($urandom));
    end
    repeat ($urandom_range(2 * size + 4, size)) random_read();
  endtask

  initial begin
    int start;
    logic [WEIGHT_BITS-1:0] edge_w [7];
    edge_w = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h0005, 16'hfffb};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    tx_idle = 0;
    rx_idle = 0;
    n_sent = 0;
    n_tensors = 0;
    n_cfg = 0;
    shadow_count = 0;
    shadow_open = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: read before any load, extremes and ties at the reset sparsity
    send(CMD_READ, '0, 1'b0, 10'd0);
    foreach (edge_w[i]) send(CMD_LOAD, edge_w[i], i == 6, '0);
    for (int i = 0; i < 8; i++) send(CMD_READ, '0, 1'b0, INDEX_BITS'(i));
    send(CMD_READ, '0, 1'b0, 10'd1023);
    set_frac('0);
    send(CMD_LOAD, 16'h8000, 1'b0, '0);
    send(CMD_READ, '0, 1'b0, 10'd0);
    send(CMD_LOAD, 16'h7fff, 1'b1, '0);
    send(CMD_READ, '0, 1'b0, 10'd1);
    set_frac(17'h1ffff);
    send(CMD_LOAD, 16'h0003, 1'b0, '0);
    send(CMD_LOAD, 16'hfffd, 1'b1, '0);
    send(CMD_READ, '0, 1'b0, 10'd0);
    send(CMD_READ, '0, 1'b0, 10'd1);

    // fill the store, then overflow it with plain loads and a last load
    set_frac(FRAC_ONE);
    for (int i = 0; i < STORE_DEPTH_DEF + 3; i++)
      send(CMD_LOAD, pick_weight(), i == STORE_DEPTH_DEF + 2, INDEX_BITS'($urandom));
    send(CMD_READ, '0, 1'b0, 10'd1023);
    send(CMD_READ, '0, 1'b0, 10'd0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 29 : (phase == 1) ? 70 : 0;
      rx_idle = (phase == 0) ? 70 : (phase == 1) ? 29 : 0;
      set_frac(pick_frac());
      start = n_sent;
      while (n_sent - start < 80) begin
        if ($urandom_range(3) == 0) set_frac(pick_frac());
        random_tensor();
        // a short burst of reads with no input idling now and then
        if ($urandom_range(4) == 0) begin
          int keep_tx;
          keep_tx = tx_idle;
          tx_idle = 0;
          repeat (12) random_read();
          tx_idle = keep_tx;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(posedge clk);
    $display("Run covered %0d items over %0d closed tensors, %0d sparsity writes,",
             n_sent, n_tensors, n_cfg);
    $display("with %0d results compared against the prediction.", checked);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
